/* sv/mvt_pkg.sv */
// Package for the 4x4 matrix-vector transform unit: data widths, default parameters,
// the operation code and the queue entry type shared by the front, queue and back.
// No dependencies.
package mvt_pkg;

  localparam int DATA_W        = 32;  // Q16.16 word
  localparam int ROW_W         = 2;   // width of the row_index field
  localparam int NUM_ELEM      = 4;   // elements per input item, results per output item
  localparam int DIM_DEF       = 4;
  localparam int FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH   = 2;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } op_e;

  typedef struct packed {
    op_e                               op;
    logic [ROW_W-1:0]                  row;
    logic [NUM_ELEM-1:0][DATA_W-1:0]   elem;
  } mvt_entry_t;

endpackage

/* sv/mvt_req_if.sv */
// Input channel of the matrix-vector transform unit: valid/ready plus one item.
// Depends on mvt_pkg.
interface mvt_req_if import mvt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [ROW_W-1:0]         row_index;
  logic signed [DATA_W-1:0] elem0;
  logic signed [DATA_W-1:0] elem1;
  logic signed [DATA_W-1:0] elem2;
  logic signed [DATA_W-1:0] elem3;

  modport source (
    output valid, func, row_index, elem0, elem1, elem2, elem3,
    input  ready
  );
  modport sink (
    input  valid, func, row_index, elem0, elem1, elem2, elem3,
    output ready
  );
endinterface

/* sv/mvt_rsp_if.sv */
// Result channel of the matrix-vector transform unit: valid/ready plus one result.
// Depends on mvt_pkg.
interface mvt_rsp_if import mvt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out0;
  logic signed [DATA_W-1:0] out1;
  logic signed [DATA_W-1:0] out2;
  logic signed [DATA_W-1:0] out3;
  logic                     saturated;

  modport source (
    output valid, out0, out1, out2, out3, saturated,
    input  ready
  );
  modport sink (
    input  valid, out0, out1, out2, out3, saturated,
    output ready
  );
endinterface

/* sv/mvt_front.sv */
// Front stage: accepts input items, decodes them into queue entries, drops loads
// that address a row beyond the matrix. Depends on mvt_pkg and mvt_req_if.
module mvt_front import mvt_pkg::*; #(
  parameter int DIM = DIM_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mvt_req_if.sink    req_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output mvt_entry_t push_entry_o
);

  logic       vld_q, vld_d;
  mvt_entry_t ent_q;
  mvt_entry_t ent_d;
  logic       keep;

  assign req_i.ready = !vld_q || push_ready_i;

  always_comb begin
    ent_d.op      = (req_i.func == 1'(OP_XFORM)) ? OP_XFORM : OP_LOAD;
    ent_d.row     = req_i.row_index;
    ent_d.elem[0] = req_i.elem0;
    ent_d.elem[1] = req_i.elem1;
    ent_d.elem[2] = req_i.elem2;
    ent_d.elem[3] = req_i.elem3;
    // drop loads aimed past the last row
    keep  = (ent_d.op == OP_XFORM) || (32'(req_i.row_index) < DIM);
    vld_d = vld_q;
    if (req_i.ready) begin
      vld_d = req_i.valid && keep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      ent_q <= ent_d;
    end
  end

  assign push_valid_o = vld_q;
  assign push_entry_o = ent_q;

endmodule

/* sv/mvt_queue.sv */
// Short FIFO between front and back so each side can stall on its own.
// Depends on mvt_pkg.
module mvt_queue import mvt_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  mvt_entry_t push_entry_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output mvt_entry_t pop_entry_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mvt_entry_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

/* sv/mvt_back.sv */
// Back end: holds the matrix, applies row loads and runs transforms through a
// multiply / sum / saturate pipeline into the result register.
// Depends on mvt_pkg and mvt_rsp_if.
module mvt_back import mvt_pkg::*; #(
  parameter int DIM       = DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  mvt_entry_t pop_entry_i,
  mvt_rsp_if.source  rsp_o
);

  // rows and columns past the fourth never reach an output
  localparam int NROW   = (DIM < NUM_ELEM) ? DIM : NUM_ELEM;
  localparam int NCOL   = NROW;
  localparam int RIDX_W = (NROW > 1) ? $clog2(NROW) : 1;
  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = PROD_W + $clog2(NCOL);
  localparam logic signed [SUM_W-1:0] SAT_HI =
    $signed({{(SUM_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}});
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  logic signed [DATA_W-1:0] mat_q  [NROW][NCOL];
  logic signed [PROD_W-1:0] prod_q [NROW][NCOL];
  logic signed [SUM_W-1:0]  sum_q  [NROW];
  logic signed [SUM_W-1:0]  sum_d  [NROW];
  logic signed [DATA_W-1:0] out_q  [NROW];
  logic signed [DATA_W-1:0] res    [NUM_ELEM];
  logic [NROW-1:0]          clip;
  logic                     sat_q;
  logic                     v_m_q, v_s_q, out_valid_q;
  logic                     en, do_load, do_xform;

  assign en          = !out_valid_q || rsp_o.ready;
  assign pop_ready_o = en;
  assign do_load     = en && pop_valid_i && (pop_entry_i.op == OP_LOAD);
  assign do_xform    = en && pop_valid_i && (pop_entry_i.op == OP_XFORM);

  // matrix store, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NROW; r++) begin
        for (int c = 0; c < NCOL; c++) begin
          mat_q[r][c] <= '0;
        end
      end
    end else if (do_load) begin
      for (int c = 0; c < NCOL; c++) begin
        mat_q[pop_entry_i.row[RIDX_W-1:0]][c] <= pop_entry_i.elem[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_m_q       <= 1'b0;
      v_s_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_m_q       <= do_xform;
      v_s_q       <= v_m_q;
      out_valid_q <= v_s_q;
    end
  end

  // multiply stage
  always_ff @(posedge clk_i) begin
    if (do_xform) begin
      for (int r = 0; r < NROW; r++) begin
        for (int c = 0; c < NCOL; c++) begin
          prod_q[r][c] <= mat_q[r][c] * $signed(pop_entry_i.elem[c]);
        end
      end
    end
  end

  // sum stage: floor-shift each product, add exactly
  always_comb begin
    for (int r = 0; r < NROW; r++) begin
      sum_d[r] = '0;
      for (int c = 0; c < NCOL; c++) begin
        sum_d[r] = sum_d[r] + SUM_W'(prod_q[r][c] >>> FRAC_BITS);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && v_m_q) begin
      for (int r = 0; r < NROW; r++) begin
        sum_q[r] <= sum_d[r];
      end
    end
  end

  // saturate stage
  always_comb begin
    for (int r = 0; r < NROW; r++) begin
      clip[r] = (sum_q[r] > SAT_HI) || (sum_q[r] < SAT_LO);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && v_s_q) begin
      for (int r = 0; r < NROW; r++) begin
        if (sum_q[r] > SAT_HI) begin
          out_q[r] <= SAT_HI[DATA_W-1:0];
        end else if (sum_q[r] < SAT_LO) begin
          out_q[r] <= SAT_LO[DATA_W-1:0];
        end else begin
          out_q[r] <= sum_q[r][DATA_W-1:0];
        end
      end
      sat_q <= |clip;
    end
  end

  for (genvar r = 0; r < NUM_ELEM; r++) begin : g_res
    if (r < NROW) begin : g_row
      assign res[r] = out_q[r];
    end else begin : g_zero
      assign res[r] = '0;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.out0      = res[0];
  assign rsp_o.out1      = res[1];
  assign rsp_o.out2      = res[2];
  assign rsp_o.out3      = res[3];
  assign rsp_o.saturated = sat_q;

`ifndef SYNTHESIS
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_load |=> !v_m_q)
    else $error("row load entered the transform pipeline");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> (v_m_q == $past(v_m_q)) && (v_s_q == $past(v_s_q)))
    else $error("pipeline advanced while the result was stalled");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(v_s_q))
    else $error("result appeared without a summed transform behind it");
`endif

endmodule

/* sv/matrix_vector_transform_4x4_unit.sv */
// Top level of the 4x4 matrix-vector transform unit: front, queue and back.
// Depends on mvt_pkg, mvt_req_if, mvt_rsp_if, mvt_front, mvt_queue, mvt_back.
//
// The unit keeps a DIM x DIM signed Q16.16 matrix (cleared to zero at reset) and
// takes one item per transfer on req_i. A load item (func = 0) writes row
// row_index from elem0..elem3 and gives no result; a load past the last row is
// dropped. A transform item (func = 1) gives one result on rsp_o: out0..out3 are
// the rows dotted with (elem0..elem3), each product floor-shifted by FRAC_BITS,
// summed exactly and saturated to 32 bits, with saturated set if any row clipped.
// Items are taken one per cycle, back to back, while the front is not held by a full
// queue; a transform passes the front register, the queue, then the multiply, sum and
// saturate registers before its result is valid, the multiply stage holding sixteen
// registered 32x32 multipliers. A load is seen by every transform that follows it.
module matrix_vector_transform_4x4_unit import mvt_pkg::*; #(
  parameter int DIM       = DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int Q_DEPTH   = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mvt_req_if.sink   req_i,
  mvt_rsp_if.source rsp_o
);

  // front -> queue
  logic       push_valid, push_ready;
  mvt_entry_t push_entry;
  // queue -> back
  logic       pop_valid, pop_ready;
  mvt_entry_t pop_entry;

  // decode and filter incoming transfers
  mvt_front #(
    .DIM (DIM)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  // hold decoded items while the back is stalled
  mvt_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  // apply loads, run transforms, drive results
  mvt_back #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .rsp_o       (rsp_o)
  );

endmodule
